>>> src/sssm_pkg.sv
// Shared types and constants for the slot sensor safety monitor.
// Request, result, configuration and classified-request structs; no dependencies.
package sssm_pkg;

    localparam int STREAK_W = 8;
    localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_STALE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAX_TEMP      = 2'd1;
    localparam logic [1:0] REG_MAX_CURRENT   = 2'd2;
    localparam logic [1:0] REG_MAX_PRESSURE  = 2'd3;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_LOST     = 3'd1;
    localparam logic [2:0] KIND_OVERTEMP = 3'd2;
    localparam logic [2:0] KIND_OVERCUR  = 3'd3;
    localparam logic [2:0] KIND_OVERPRES = 3'd4;

    localparam logic [22:0] CUR_ABS_MAX = 23'h7FFFFF;

    typedef struct packed {
        logic [1:0]         slot_index;
        logic               checks_off;
        logic               job_active;
        logic               temp_valid;
        logic [31:0]        temp_age_ms;
        logic signed [15:0] temp_value;
        logic               current_valid;
        logic               current_stale;
        logic signed [23:0] current_value;
        logic               pressure_valid;
        logic [31:0]        pressure_age_ms;
        logic signed [15:0] pressure_value;
    } t_req;

    typedef struct packed {
        logic       evaluated;
        logic       fault_found;
        logic [2:0] fault_kind;
        logic       fault_global;
        logic [1:0] fault_slot;
    } t_rsp;

    typedef struct packed {
        logic [31:0]        stale_timeout_ms;
        logic signed [15:0] max_temperature;
        logic [22:0]        max_current;
        logic signed [15:0] max_pressure;
    } t_cfg;

    typedef struct packed {
        logic [1:0] slot;
        logic       off;
        logic       run;
        logic       temp_bad;
        logic       pres_bad;
        logic       over_temp;
        logic       over_cur;
        logic       over_pres;
    } t_cls;

endpackage

>>> src/sssm_front.sv
// Front end: takes requests while the queue has room and classifies them.
// Depends on sssm_pkg and sssm_classify.
module sssm_front (
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  sssm_pkg::t_req i_req,
    input  sssm_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output sssm_pkg::t_cls o_cls
);

    assign o_req_ready = !i_q_full;
    assign o_push      = i_req_valid && !i_q_full;

    sssm_classify u_classify (
        .i_req (i_req),
        .i_cfg (i_cfg),
        .o_cls (o_cls)
    );

endmodule

>>> src/sssm_classify.sv
// Front end: classifies one request against the configured limits.
// Depends on sssm_pkg.
module sssm_classify (
    input  sssm_pkg::t_req i_req,
    input  sssm_pkg::t_cfg i_cfg,
    output sssm_pkg::t_cls o_cls
);

    logic [23:0] cur_mag;
    logic [22:0] cur_abs;

    always_comb begin
        cur_mag = i_req.current_value[23] ? (24'd0 - i_req.current_value) : i_req.current_value;
        cur_abs = cur_mag[23] ? sssm_pkg::CUR_ABS_MAX : cur_mag[22:0];
    end

    always_comb begin
        o_cls.slot      = i_req.slot_index;
        o_cls.off       = i_req.checks_off;
        o_cls.run       = i_req.job_active;
        o_cls.temp_bad  = !i_req.temp_valid
                          || (i_req.temp_age_ms > i_cfg.stale_timeout_ms);
        o_cls.pres_bad  = !i_req.pressure_valid
                          || (i_req.pressure_age_ms > i_cfg.stale_timeout_ms);
        o_cls.over_temp = i_req.temp_valid && (i_req.temp_value > i_cfg.max_temperature);
        o_cls.over_cur  = i_req.current_valid && !i_req.current_stale
                          && (cur_abs > i_cfg.max_current);
        o_cls.over_pres = i_req.pressure_valid
                          && (i_req.pressure_value > i_cfg.max_pressure);
    end

endmodule

>>> src/sssm_queue.sv
// Two-entry queue of classified requests between front and back ends.
// Depends on sssm_pkg.
module sssm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sssm_pkg::t_cls i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sssm_pkg::t_cls o_data
);

    sssm_pkg::t_cls r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> src/sssm_back.sv
// Back end: per-slot streaks, scan state, fault priority and result register.
// Depends on sssm_pkg.
module sssm_back #(
    parameter int SLOTS       = 4,
    parameter int STREAK_TRIP = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cls_valid,
    input  sssm_pkg::t_cls i_cls,
    output logic           o_pop,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output sssm_pkg::t_rsp o_rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [sssm_pkg::STREAK_W-1:0] TRIP = sssm_pkg::STREAK_W'(STREAK_TRIP);

    logic [sssm_pkg::STREAK_W-1:0] r_temp_streak [SLOTS];
    logic [sssm_pkg::STREAK_W-1:0] r_pres_streak [SLOTS];
    logic                          r_scan_ended;
    logic                          r_rsp_valid;
    sssm_pkg::t_rsp                r_rsp;

    logic                          n_scan_ended;
    sssm_pkg::t_rsp                n_rsp;
    logic [sssm_pkg::STREAK_W-1:0] n_temp;
    logic [sssm_pkg::STREAK_W-1:0] n_pres;
    logic [IDX_W-1:0]              idx;
    logic                          in_range;
    logic                          skip;
    logic                          wr_streak;
    logic [sssm_pkg::STREAK_W-1:0] cur_temp;
    logic [sssm_pkg::STREAK_W-1:0] cur_pres;
    logic [2:0]                    kind;
    logic                          glob;

    assign o_pop       = i_cls_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        idx      = IDX_W'(i_cls.slot);
        in_range = (32'(i_cls.slot) < 32'(SLOTS));
        skip     = ((i_cls.slot != 2'd0) && r_scan_ended) || i_cls.off || !in_range;
        cur_temp = in_range ? r_temp_streak[idx] : '0;
        cur_pres = in_range ? r_pres_streak[idx] : '0;

        n_temp = '0;
        n_pres = '0;
        if (i_cls.run && i_cls.temp_bad) begin
            n_temp = (cur_temp == sssm_pkg::STREAK_MAX) ? cur_temp
                     : cur_temp + sssm_pkg::STREAK_W'(1);
        end
        if (i_cls.run && i_cls.pres_bad) begin
            n_pres = (cur_pres == sssm_pkg::STREAK_MAX) ? cur_pres
                     : cur_pres + sssm_pkg::STREAK_W'(1);
        end

        kind = sssm_pkg::KIND_NONE;
        glob = 1'b0;
        if (!skip && i_cls.run) begin
            if (n_temp >= TRIP) begin
                kind = sssm_pkg::KIND_LOST;
            end else if (i_cls.over_temp) begin
                kind = sssm_pkg::KIND_OVERTEMP;
            end else if (i_cls.over_cur) begin
                kind = sssm_pkg::KIND_OVERCUR;
            end else if (n_pres >= TRIP) begin
                kind = sssm_pkg::KIND_LOST;
                glob = 1'b1;
            end else if (i_cls.over_pres) begin
                kind = sssm_pkg::KIND_OVERPRES;
                glob = 1'b1;
            end
        end

        wr_streak          = o_pop && !skip;
        n_rsp.evaluated    = !skip;
        n_rsp.fault_found  = (kind != sssm_pkg::KIND_NONE);
        n_rsp.fault_kind   = kind;
        n_rsp.fault_global = glob;
        n_rsp.fault_slot   = (n_rsp.fault_found && !glob) ? i_cls.slot : 2'd0;
        n_scan_ended       = ((i_cls.slot != 2'd0) && r_scan_ended) || n_rsp.fault_found;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_ended <= 1'b0;
            r_rsp_valid  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_temp_streak[i] <= '0;
                r_pres_streak[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_scan_ended <= n_scan_ended;
                r_rsp_valid  <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid  <= 1'b0;
            end
            if (wr_streak) begin
                r_temp_streak[idx] <= n_temp;
                r_pres_streak[idx] <= n_pres;
            end
        end
    end

endmodule

>>> src/slot_sensor_safety_monitor_top.sv
// Channel     | Signals                              | Transfer
// ------------+--------------------------------------+--------------------------------
// request in  | i_req_valid, o_req_ready, i_req      | i_req_valid && o_req_ready
// result out  | o_rsp_valid, i_rsp_ready, o_rsp      | o_rsp_valid && i_rsp_ready
// config      | psel, penable, pwrite, paddr, pwdata | psel && penable && pwrite
//
// One request per cycle sustained while the queue has room; a taken request passes through the
// queue and then the back end's result register before its result is offered.
// The per-request loop is the back end's streak read-modify-write and scan-ended flag.
// A two-entry queue parts front and back; o_req_ready drops only when it is full.
// Synchronous reset clears streaks, scan state and queue.
// Top level: configuration registers, front end, queue and back end.
// Depends on sssm_pkg, sssm_front, sssm_classify, sssm_queue, sssm_back.
module slot_sensor_safety_monitor_top #(
    parameter int SLOTS       = 4,
    parameter int STREAK_TRIP = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  sssm_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output sssm_pkg::t_rsp                o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sssm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    sssm_pkg::t_cfg r_cfg;
    sssm_pkg::t_cls front_cls;
    sssm_pkg::t_cls q_cls;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           q_push;
    logic           cfg_wr;
    logic [1:0]     reg_sel;

    assign pready      = 1'b1;
    assign reg_sel     = paddr[3:2];
    assign cfg_wr      = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_sel)
            sssm_pkg::REG_STALE_TIMEOUT: prdata = r_cfg.stale_timeout_ms;
            sssm_pkg::REG_MAX_TEMP:      prdata = 32'(r_cfg.max_temperature);
            sssm_pkg::REG_MAX_CURRENT:   prdata = {9'd0, r_cfg.max_current};
            sssm_pkg::REG_MAX_PRESSURE:  prdata = 32'(r_cfg.max_pressure);
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_timeout_ms <= 32'd1000;
            r_cfg.max_temperature  <= 16'sd800;
            r_cfg.max_current      <= 23'd10000;
            r_cfg.max_pressure     <= 16'sd10000;
        end else if (cfg_wr) begin
            case (reg_sel)
                sssm_pkg::REG_STALE_TIMEOUT: r_cfg.stale_timeout_ms <= pwdata;
                sssm_pkg::REG_MAX_TEMP:      r_cfg.max_temperature  <= pwdata[15:0];
                sssm_pkg::REG_MAX_CURRENT:   r_cfg.max_current      <= pwdata[22:0];
                sssm_pkg::REG_MAX_PRESSURE:  r_cfg.max_pressure     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    sssm_front u_front (
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cls       (front_cls)
    );

    sssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    sssm_back #(
        .SLOTS       (SLOTS),
        .STREAK_TRIP (STREAK_TRIP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (q_valid),
        .i_cls       (q_cls),
        .o_pop       (q_pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

>>> src/sssm_checker.sv
// Port-level checker for the safety monitor top level, with its bind.
// Depends on sssm_pkg and slot_sensor_safety_monitor_top.
module sssm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input sssm_pkg::t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    a_fault_evaluated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.fault_found |-> o_rsp.evaluated
            && o_rsp.fault_kind != sssm_pkg::KIND_NONE)
        else $error("fault on a slot that was not evaluated");

    a_clean_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.fault_found |-> o_rsp.fault_kind == sssm_pkg::KIND_NONE
            && !o_rsp.fault_global && o_rsp.fault_slot == 2'd0)
        else $error("fault fields set without a fault");

    a_global_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.fault_global |-> o_rsp.fault_slot == 2'd0
            && (o_rsp.fault_kind == sssm_pkg::KIND_LOST
                || o_rsp.fault_kind == sssm_pkg::KIND_OVERPRES))
        else $error("global fault with wrong kind or slot");

endmodule

bind slot_sensor_safety_monitor_top sssm_checker u_sssm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

>>> tb/tb_slot_sensor_safety_monitor_top.sv
// Self-checking testbench for slot_sensor_safety_monitor_top: directed slot checks, then random
// scans under several limit settings, with a scoreboard that predicts every verdict.
// Depends on sssm_pkg and the RTL of the monitor.
module tb_slot_sensor_safety_monitor_top;

    localparam int SLOTS       = 4;
    localparam int STREAK_TRIP = 3;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {RSP_OPEN, RSP_COIN, RSP_EVERY4, RSP_SPARSE} t_ready_mode;

    class fault_verdict_board;
        logic [31:0]                   stale_ms;
        logic signed [15:0]            temp_limit;
        logic [22:0]                   cur_limit;
        logic signed [15:0]            pres_limit;
        logic [sssm_pkg::STREAK_W-1:0] temp_streak [SLOTS];
        logic [sssm_pkg::STREAK_W-1:0] pres_streak [SLOTS];
        logic                          scan_over;
        sssm_pkg::t_rsp                verdicts_due [$];
        int                            failures;

        function new();
            stale_ms   = 32'd1000;
            temp_limit = 16'sd800;
            cur_limit  = 23'd10000;
            pres_limit = 16'sd10000;
            foreach (temp_streak[i]) begin
                temp_streak[i] = '0;
                pres_streak[i] = '0;
            end
            scan_over = 1'b0;
            failures  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                sssm_pkg::REG_STALE_TIMEOUT: stale_ms   = val;
                sssm_pkg::REG_MAX_TEMP:      temp_limit = val[15:0];
                sssm_pkg::REG_MAX_CURRENT:   cur_limit  = val[22:0];
                sssm_pkg::REG_MAX_PRESSURE:  pres_limit = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [sssm_pkg::STREAK_W-1:0] advance_streak(
            logic [sssm_pkg::STREAK_W-1:0] cnt, logic bad);
            if (!bad)
                return '0;
            return (cnt == sssm_pkg::STREAK_MAX) ? cnt : cnt + 1'b1;
        endfunction

        function sssm_pkg::t_rsp judge_slot(sssm_pkg::t_req r);
            sssm_pkg::t_rsp v;
            logic [1:0]     s;
            logic           t_bad;
            logic           p_bad;
            logic [23:0]    mag;
            logic [22:0]    acur;
            logic [2:0]     kind;
            logic           glob;
            v    = '0;
            s    = r.slot_index;
            kind = sssm_pkg::KIND_NONE;
            glob = 1'b0;
            if (s == 2'd0)
                scan_over = 1'b0;
            if (scan_over || r.checks_off || int'(s) >= SLOTS)
                return v;
            v.evaluated = 1'b1;
            if (!r.job_active) begin
                temp_streak[s] = '0;
                pres_streak[s] = '0;
                return v;
            end
            t_bad = !r.temp_valid || (r.temp_age_ms > stale_ms);
            p_bad = !r.pressure_valid || (r.pressure_age_ms > stale_ms);
            temp_streak[s] = advance_streak(temp_streak[s], t_bad);
            pres_streak[s] = advance_streak(pres_streak[s], p_bad);
            mag  = r.current_value[23] ? ~r.current_value + 24'd1 : r.current_value;
            acur = mag[23] ? sssm_pkg::CUR_ABS_MAX : mag[22:0];
            if (temp_streak[s] >= STREAK_TRIP) begin
                kind = sssm_pkg::KIND_LOST;
            end else if (r.temp_valid && $signed(r.temp_value) > $signed(temp_limit)) begin
                kind = sssm_pkg::KIND_OVERTEMP;
            end else if (r.current_valid && !r.current_stale && acur > cur_limit) begin
                kind = sssm_pkg::KIND_OVERCUR;
            end else if (pres_streak[s] >= STREAK_TRIP) begin
                kind = sssm_pkg::KIND_LOST;
                glob = 1'b1;
            end else if (r.pressure_valid
                         && $signed(r.pressure_value) > $signed(pres_limit)) begin
                kind = sssm_pkg::KIND_OVERPRES;
                glob = 1'b1;
            end
            if (kind != sssm_pkg::KIND_NONE) begin
                scan_over      = 1'b1;
                v.fault_found  = 1'b1;
                v.fault_kind   = kind;
                v.fault_global = glob;
                v.fault_slot   = glob ? 2'd0 : s;
            end
            return v;
        endfunction

        function void take_request(sssm_pkg::t_req r);
            verdicts_due.push_back(judge_slot(r));
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void log_failure(string what, sssm_pkg::t_rsp want, sssm_pkg::t_rsp got);
            failures++;
            if (failures <= 10)
                $display("%s at %0t: expected e%b f%b k%0d g%b s%0d, got e%b f%b k%0d g%b s%0d",
                         what, $time, want.evaluated, want.fault_found, want.fault_kind,
                         want.fault_global, want.fault_slot, got.evaluated, got.fault_found,
                         got.fault_kind, got.fault_global, got.fault_slot);
        endfunction

        function void check_verdict(sssm_pkg::t_rsp got);
            sssm_pkg::t_rsp want;
            if (verdicts_due.size() == 0) begin
                log_failure("unexpected result", '0, got);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.evaluated !== want.evaluated || got.fault_found !== want.fault_found
                || got.fault_kind !== want.fault_kind || got.fault_global !== want.fault_global
                || got.fault_slot !== want.fault_slot)
                log_failure("result mismatch", want, got);
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_req_valid = 1'b0;
    logic                            o_req_ready;
    sssm_pkg::t_req                  i_req       = '0;
    logic                            o_rsp_valid;
    logic                            i_rsp_ready = 1'b0;
    sssm_pkg::t_rsp                  o_rsp;
    logic                            psel        = 1'b0;
    logic                            penable     = 1'b0;
    logic                            pwrite      = 1'b0;
    logic [sssm_pkg::CFG_ADDR_W-1:0] paddr       = '0;
    logic [31:0]                     pwdata      = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    fault_verdict_board board;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int bad_pct      = 10;
    bit gaps_on      = 1'b1;
    bit long_hold    = 1'b0;

    slot_sensor_safety_monitor_top #(
        .SLOTS       (SLOTS),
        .STREAK_TRIP (STREAK_TRIP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            board.check_verdict(o_rsp);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)
            || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic sssm_pkg::t_req calm(logic [1:0] slot);
        sssm_pkg::t_req r;
        r                = '0;
        r.slot_index     = slot;
        r.job_active     = 1'b1;
        r.temp_valid     = 1'b1;
        r.temp_value     = 16'sd200;
        r.current_valid  = 1'b1;
        r.current_value  = 24'sd100;
        r.pressure_valid = 1'b1;
        r.pressure_value = 16'sd1000;
        return r;
    endfunction

    function automatic logic [31:0] age_for(logic [31:0] lim);
        if ($urandom_range(0, 99) < bad_pct) begin
            case ($urandom_range(0, 2))
                0: return lim + 32'd1;
                1: return $urandom;
                default: return lim + 32'($urandom_range(1, 1000));
            endcase
        end
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return lim;
            default: return (lim < 32'd64) ? 32'($urandom_range(0, lim))
                                           : lim - 32'($urandom_range(1, 63));
        endcase
    endfunction

    function automatic logic signed [15:0] near16(logic signed [15:0] lim);
        int v;
        case ($urandom_range(0, 15))
            0: return 16'($urandom);
            1: v = int'(lim) + 1;
            2: v = int'(lim);
            default: v = int'(lim) - int'($urandom_range(1, 3000));
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic logic signed [23:0] near_current(logic [22:0] lim);
        int m;
        case ($urandom_range(0, 15))
            0: return 24'($urandom);
            1: return 24'sh800000;
            2: m = int'(lim) + 1;
            3: m = int'(lim);
            default: m = int'($urandom_range(0, lim));
        endcase
        return ($urandom_range(0, 1) != 0) ? 24'(-m) : 24'(m);
    endfunction

    function automatic sssm_pkg::t_req scan_req(logic [1:0] slot);
        sssm_pkg::t_req r;
        r.slot_index      = slot;
        r.checks_off      = ($urandom_range(0, 19) == 0);
        r.job_active      = ($urandom_range(0, 9) != 0);
        r.temp_valid      = ($urandom_range(0, 99) >= bad_pct);
        r.temp_age_ms     = age_for(board.stale_ms);
        r.temp_value      = near16(board.temp_limit);
        r.current_valid   = ($urandom_range(0, 9) != 0);
        r.current_stale   = ($urandom_range(0, 9) == 0);
        r.current_value   = near_current(board.cur_limit);
        r.pressure_valid  = ($urandom_range(0, 99) >= bad_pct);
        r.pressure_age_ms = age_for(board.stale_ms);
        r.pressure_value  = near16(board.pres_limit);
        return r;
    endfunction

    task automatic offer_request(input sssm_pkg::t_req r);
        int gap;
        i_req       <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready)
            @(posedge i_clk);
        board.take_request(r);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        board.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [31:0] stale, input logic signed [15:0] t_lim,
                              input logic [22:0] c_lim, input logic signed [15:0] p_lim);
        drain();
        write_reg(sssm_pkg::REG_STALE_TIMEOUT, stale);
        write_reg(sssm_pkg::REG_MAX_TEMP, {{16{t_lim[15]}}, t_lim});
        write_reg(sssm_pkg::REG_MAX_CURRENT, {9'd0, c_lim});
        write_reg(sssm_pkg::REG_MAX_PRESSURE, {{16{p_lim[15]}}, p_lim});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bad_pct = $urandom_range(3, 30);
    endtask

    task automatic run_phase(input int count);
        int             sent;
        int             n;
        int             s;
        sssm_pkg::t_req r;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    r = {$urandom, $urandom, $urandom, $urandom};
                    offer_request(r);
                    sent++;
                end
                1, 2: begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        offer_request(scan_req(2'($urandom)));
                        sent++;
                    end
                end
                default: begin
                    for (s = 0; s < SLOTS; s++) begin
                        offer_request(scan_req(2'(s)));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic saturate_streaks(input int count);
        sssm_pkg::t_req r;
        repeat (count) begin
            r                = scan_req(2'd0);
            r.checks_off     = 1'b0;
            r.job_active     = 1'b1;
            r.temp_valid     = 1'b0;
            r.pressure_valid = 1'b0;
            offer_request(r);
        end
        r                = calm(2'd0);
        r.pressure_valid = 1'b0;
        offer_request(r);
        offer_request(calm(2'd0));
    endtask

    initial begin : rsp_side
        t_ready_mode mode;
        int          span;
        int          tick;
        tick = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            mode = t_ready_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                if (long_hold) begin
                    long_hold = 1'b0;
                    i_rsp_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    RSP_OPEN:   i_rsp_ready <= 1'b1;
                    RSP_COIN:   i_rsp_ready <= ($urandom_range(0, 1) != 0);
                    RSP_EVERY4: i_rsp_ready <= (tick % 4) != 0;
                    default:    i_rsp_ready <= ($urandom_range(0, 5) == 0);
                endcase
                tick++;
                @(negedge i_clk);
            end
        end
    end

    initial begin : req_side
        sssm_pkg::t_req r;
        board = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        r = calm(2'd0);
        offer_request(r);
        r = calm(2'd1);
        r.temp_value = 16'sd801;
        offer_request(r);
        r = calm(2'd2);
        offer_request(r);
        r = calm(2'd3);
        r.checks_off = 1'b1;
        offer_request(r);
        r = calm(2'd0);
        r.temp_value    = 16'sd800;
        r.current_value = 24'sh800000;
        offer_request(r);
        r = calm(2'd0);
        r.current_value = 24'sd10001;
        r.current_stale = 1'b1;
        offer_request(r);
        r = calm(2'd1);
        r.current_value = -24'sd10001;
        offer_request(r);
        r = calm(2'd0);
        r.pressure_value = 16'sd10001;
        r.current_value  = 24'sd10000;
        offer_request(r);
        r = calm(2'd0);
        r.checks_off = 1'b1;
        offer_request(r);
        r = calm(2'd2);
        r.temp_valid = 1'b0;
        r.temp_value = 16'sh7FFF;
        offer_request(r);
        r = calm(2'd2);
        r.temp_age_ms = 32'd1001;
        offer_request(r);
        r = calm(2'd2);
        r.temp_age_ms   = 32'hFFFF_FFFF;
        r.current_value = 24'sh7FFFFF;
        offer_request(r);
        r = calm(2'd3);
        r.temp_value = 16'sh7FFF;
        offer_request(r);
        r = calm(2'd0);
        r.job_active = 1'b0;
        r.temp_valid = 1'b0;
        offer_request(r);
        r = calm(2'd2);
        r.job_active = 1'b0;
        offer_request(r);
        r = calm(2'd2);
        r.temp_valid = 1'b0;
        offer_request(r);
        r = calm(2'd1);
        r.pressure_valid = 1'b0;
        r.temp_value     = 16'sh8000;
        r.current_valid  = 1'b0;
        r.current_value  = 24'sh800000;
        r.pressure_value = 16'sh8000;
        offer_request(r);
        r = calm(2'd1);
        r.pressure_age_ms = 32'd1001;
        offer_request(r);
        r = calm(2'd1);
        r.pressure_age_ms = 32'hFFFF_FFFF;
        r.temp_age_ms     = 32'd1000;
        offer_request(r);
        r = calm(2'd3);
        offer_request(r);
        r = calm(2'd0);
        r.pressure_age_ms = 32'd1000;
        offer_request(r);
        offer_request(calm(2'd3));
        offer_request(calm(2'd1));
        r = calm(2'd1);
        r.temp_value     = 16'sd900;
        r.current_value  = 24'sd20000;
        r.pressure_value = 16'sd20000;
        offer_request(r);
        r = calm(2'd0);
        r.current_value  = -24'sd20000;
        r.pressure_value = 16'sh7FFF;
        offer_request(r);

        set_limits(32'd0, 16'sh8000, 23'd0, 16'sh8000);
        run_phase(PHASE_ITEMS);

        set_limits(32'hFFFF_FFFF, 16'sh7FFF, 23'h7FFFFF, 16'sh7FFF);
        gaps_on = 1'b0;
        run_phase(PHASE_ITEMS);
        gaps_on = 1'b1;

        set_limits(32'd1000, 16'sd800, 23'd10000, 16'sd10000);
        saturate_streaks(262);
        run_phase(PHASE_ITEMS / 2);
        long_hold = 1'b1;
        run_phase(PHASE_ITEMS / 2);

        set_limits(32'($urandom_range(0, 3000)), 16'($urandom_range(0, 1500)),
                   23'($urandom_range(0, 20000)), 16'($urandom_range(0, 15000)));
        run_phase(PHASE_ITEMS);

        set_limits($urandom, 16'($urandom), 23'($urandom), 16'($urandom));
        run_phase(PHASE_ITEMS);

        drain();
        repeat (6) @(negedge i_clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
